FILE: src/i2cm_pkg.sv
// Shared types and codes for the I2C master bit engine.
// No dependencies; imported by every module of the block.
package i2cm_pkg;

    // Command codes carried by a tick
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_STOP  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_WAIT  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd100;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

    // One tick as it enters the sequencer
    typedef struct packed {
        logic       command_valid;
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_item;

    // Line and status view after one tick
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } t_res;

endpackage

FILE: src/i2cm_seq.sv
// Bus sequencer: phase machine, half-bit delay counter, shift register, ack poll.
// Depends on i2cm_pkg (t_item, t_res, command codes).
module i2cm_seq import i2cm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_item       i_item,
    input  logic [15:0] i_half_period,
    input  logic [7:0]  i_ack_timeout,
    output t_res        o_res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_WA1, PH_WA2, PH_POLL,
        PH_WRH, PH_WRL, PH_RDL, PH_RDH, PH_AKL, PH_AKH
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_bit_cnt, n_bit_cnt;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_delay, n_delay;
    logic [8:0]  r_poll, n_poll;
    logic        r_ack_choice, n_ack_choice;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_drive, n_drive;
    logic        r_err, n_err;
    logic [7:0]  r_rx, n_rx;
    logic        done;

    logic [15:0] hp_eff;
    logic [3:0]  bit_inc;
    logic [8:0]  poll_inc;
    logic        poll_over;

    assign hp_eff    = (i_half_period == 16'd0) ? 16'd1 : i_half_period;
    assign bit_inc   = r_bit_cnt + 4'd1;
    assign poll_inc  = r_poll + 9'd1;
    assign poll_over = poll_inc > {1'b0, i_ack_timeout};

    always_comb begin
        n_phase      = r_phase;
        n_bit_cnt    = r_bit_cnt;
        n_shift      = r_shift;
        n_delay      = r_delay;
        n_poll       = r_poll;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_drive      = r_drive;
        n_err        = r_err;
        n_rx         = r_rx;
        done         = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_item.command_valid) begin
                case (i_item.command)
                    CMD_START: begin
                        n_drive = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                        n_phase = PH_ST1; n_delay = hp_eff;
                    end
                    CMD_STOP: begin
                        n_drive = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                        n_phase = PH_SP1; n_delay = hp_eff;
                    end
                    CMD_WRITE: begin
                        n_drive   = 1'b1;
                        n_bit_cnt = 4'd0;
                        n_sda     = i_item.tx_byte[7];
                        n_shift   = {i_item.tx_byte[6:0], 1'b0};
                        n_scl     = 1'b1;
                        n_phase   = PH_WRH; n_delay = hp_eff;
                    end
                    CMD_READ: begin
                        n_drive = 1'b0; n_scl = 1'b0;
                        n_ack_choice = i_item.send_ack;
                        n_shift = 8'd0; n_bit_cnt = 4'd0;
                        n_phase = PH_RDL; n_delay = hp_eff;
                    end
                    CMD_WAIT: begin
                        n_drive = 1'b0; n_poll = 9'd0;
                        n_phase = PH_WA1; n_delay = hp_eff;
                    end
                    default: ;
                endcase
            end
        end else if (r_phase == PH_POLL || (r_phase == PH_WA2 && r_delay <= 16'd1)) begin
            // ack poll: first poll falls on the tick the high wait ends
            n_phase = PH_POLL;
            n_delay = 16'd0;
            if (!i_item.sda_in) begin
                n_scl = 1'b0; n_err = 1'b0;
                n_phase = PH_IDLE; done = 1'b1;
            end else begin
                n_poll = poll_inc;
                if (poll_over) begin
                    n_err = 1'b1;
                    n_drive = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                    n_phase = PH_SP1; n_delay = hp_eff;
                end
            end
        end else if (r_delay > 16'd1) begin
            n_delay = r_delay - 16'd1;
        end else begin
            n_delay = hp_eff;
            case (r_phase)
                PH_ST1: begin n_sda = 1'b0; n_phase = PH_ST2; end
                PH_ST2: begin
                    n_scl = 1'b0; n_phase = PH_IDLE; n_delay = 16'd0; done = 1'b1;
                end
                PH_SP1: begin n_scl = 1'b1; n_sda = 1'b1; n_phase = PH_SP2; end
                PH_WA1: begin n_scl = 1'b1; n_phase = PH_WA2; end
                PH_WRH: begin n_scl = 1'b0; n_phase = PH_WRL; end
                PH_WRL: begin
                    n_bit_cnt = bit_inc;
                    if (bit_inc[3]) begin
                        n_phase = PH_IDLE; n_delay = 16'd0; done = 1'b1;
                    end else begin
                        n_sda   = r_shift[7];
                        n_shift = {r_shift[6:0], 1'b0};
                        n_scl   = 1'b1;
                        n_phase = PH_WRH;
                    end
                end
                PH_RDL: begin
                    n_scl   = 1'b1;
                    n_shift = {r_shift[6:0], i_item.sda_in};
                    n_phase = PH_RDH;
                end
                PH_RDH: begin
                    n_bit_cnt = bit_inc;
                    n_scl     = 1'b0;
                    if (bit_inc[3]) begin
                        n_rx    = r_shift;
                        n_drive = 1'b1;
                        n_sda   = ~r_ack_choice;
                        n_phase = PH_AKL;
                    end else begin
                        n_phase = PH_RDL;
                    end
                end
                PH_AKL: begin n_scl = 1'b1; n_phase = PH_AKH; end
                PH_AKH: begin
                    n_scl = 1'b0; n_phase = PH_IDLE; n_delay = 16'd0; done = 1'b1;
                end
                default: begin
                    // end of stop, or a phase that should not wait
                    n_phase = PH_IDLE; n_delay = 16'd0; done = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_res.scl       = n_scl;
        o_res.sda_out   = n_drive ? n_sda : 1'b1;
        o_res.sda_drive = n_drive;
        o_res.busy_res  = (n_phase != PH_IDLE);
        o_res.done_res  = done;
        o_res.rx_byte   = n_rx;
        o_res.ack_error = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_cnt    <= 4'd0;
            r_shift      <= 8'd0;
            r_delay      <= 16'd0;
            r_poll       <= 9'd0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_drive      <= 1'b0;
            r_err        <= 1'b0;
            r_rx         <= 8'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bit_cnt    <= n_bit_cnt;
            r_shift      <= n_shift;
            r_delay      <= n_delay;
            r_poll       <= n_poll;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_drive      <= n_drive;
            r_err        <= n_err;
            r_rx         <= n_rx;
        end
    end

endmodule

FILE: src/i2cm_out_buf.sv
// Result register with a skid entry so the sequencer keeps going one
// transaction past a stall. Depends on i2cm_pkg (t_res).
module i2cm_out_buf import i2cm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    output logic o_full,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);

    logic r_out_valid, r_skid_valid;
    t_res r_out, r_skid;
    logic take;

    assign take    = r_out_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out        <= r_skid;
                r_skid_valid <= i_push;
                r_skid       <= i_res;
            end else begin
                r_out_valid <= i_push;
                r_out       <= i_res;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
            r_skid       <= i_res;
        end
    end

endmodule

FILE: src/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: tick input register, config regs,
// sequencer and result buffer. Depends on i2cm_pkg, i2cm_seq, i2cm_out_buf.
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ------------------------------------
//  tick in   in         i_in_valid / o_in_stall    command_valid command tx_byte send_ack sda_in
//  result    out        o_out_valid / i_out_stall  scl sda_out sda_drive busy done rx ack_error
//  config    in         i_cfg_we (no stall)        i_cfg_idx, i_cfg_data
//
// One tick transaction per clock, sustained while o_in_stall is low. Each tick is
// registered, the sequencer works it out when it steps, and its result is
// registered in the output register, or in the skid entry when that is held.
// The output register plus a skid entry let the input keep flowing for one
// transaction after the output stalls; o_in_stall rises only when both are full.
// Synchronous active-low reset: lines idle (SCL high, SDA released), phase
// idle, half period 100 ticks, ack timeout 250 polls.
module i2c_master_bit_engine import i2cm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command_valid,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_send_ack,
    input  logic        i_sda_in,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_scl,
    output logic        o_sda_out,
    output logic        o_sda_drive,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_rx_byte,
    output logic        o_ack_error,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_half_period;
    logic [7:0]  r_ack_timeout;

    logic  r_in_valid;
    t_item r_item;
    logic  buf_full;
    logic  step;
    logic  in_accept;
    t_res  seq_res;
    t_res  out_res;

    // Sequencer advances whenever a registered tick is waiting and the
    // skid entry is free to catch its result.
    assign step       = r_in_valid && !buf_full;
    assign o_in_stall = r_in_valid && buf_full;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HALF_PERIOD: r_half_period <= i_cfg_data;
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    // tick payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.command_valid <= i_command_valid;
            r_item.command       <= i_command;
            r_item.tx_byte       <= i_tx_byte;
            r_item.send_ack      <= i_send_ack;
            r_item.sda_in        <= i_sda_in;
        end
    end

    i2cm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (r_item),
        .i_half_period (r_half_period),
        .i_ack_timeout (r_ack_timeout),
        .o_res         (seq_res)
    );

    i2cm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_res   (seq_res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    assign o_scl       = out_res.scl;
    assign o_sda_out   = out_res.sda_out;
    assign o_sda_drive = out_res.sda_drive;
    assign o_busy_res  = out_res.busy_res;
    assign o_done_res  = out_res.done_res;
    assign o_rx_byte   = out_res.rx_byte;
    assign o_ack_error = out_res.ack_error;

    // done pulse only when the sequence has ended
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while busy");

    // released SDA always reads as high level
    a_release_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_sda_drive |-> o_sda_out)
        else $error("sda_out low while released");

    // input backs up only when the result side holds a transaction
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result register");

endmodule
